// ===== hw/rtl/vtl_pkg.sv =====
// ----------------------------------------------------------------------------
// vtl_pkg: shared types and constants for the vector to lon/lat converter
// Holds the cell payload types, the arctangent table and the angle constants.
// ----------------------------------------------------------------------------
package vtl_pkg;

	localparam int N_ITER     = 32;
	localparam int IDX_W      = 5;
	localparam int VEC_W      = 64;
	localparam int ACC_W      = 40;
	localparam int PRE_SHIFT  = 27;
	localparam int RND_SHIFT  = 8;
	localparam int LATENCY    = 68;

	localparam logic signed [ACC_W-1:0] RND_HALF  = 40'sd128;
	localparam logic signed [ACC_W-1:0] HALF_TURN = 40'sd193273528320;
	localparam logic signed [31:0]      FULL_TURN = 32'sd1509949440;
	localparam logic signed [29:0]      QUARTER   = 30'sd377487360;
	localparam logic [28:0]             POLE_RST  = 29'd377487359;

	typedef struct packed {
		logic [VEC_W-1:0] rem;
		logic [VEC_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] xa;
		logic signed [VEC_W-1:0] yb;
		logic signed [ACC_W-1:0] ang;
	} cd_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} vec_t;

	typedef struct packed {
		logic last;
		logic xy_zero;
		logic x_neg;
		logic z_pos;
		logic z_neg;
	} flags_t;

	// arctangent of 2^-i in 2^-30 degree units
	function automatic logic signed [ACC_W-1:0] atan_tab(input logic [IDX_W-1:0] idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			5'd0:  v = 40'sd48318382080;
			5'd1:  v = 40'sd28524006506;
			5'd2:  v = 40'sd15071301663;
			5'd3:  v = 40'sd7650428051;
			5'd4:  v = 40'sd3840059795;
			5'd5:  v = 40'sd1921901881;
			5'd6:  v = 40'sd961185452;
			5'd7:  v = 40'sd480622056;
			5'd8:  v = 40'sd240314695;
			5'd9:  v = 40'sd120157806;
			5'd10: v = 40'sd60078960;
			5'd11: v = 40'sd30039487;
			5'd12: v = 40'sd15019745;
			5'd13: v = 40'sd7509872;
			5'd14: v = 40'sd3754936;
			5'd15: v = 40'sd1877468;
			5'd16: v = 40'sd938734;
			5'd17: v = 40'sd469367;
			5'd18: v = 40'sd234684;
			5'd19: v = 40'sd117342;
			5'd20: v = 40'sd58671;
			5'd21: v = 40'sd29335;
			5'd22: v = 40'sd14668;
			5'd23: v = 40'sd7334;
			5'd24: v = 40'sd3667;
			5'd25: v = 40'sd1833;
			5'd26: v = 40'sd917;
			5'd27: v = 40'sd458;
			5'd28: v = 40'sd229;
			5'd29: v = 40'sd115;
			5'd30: v = 40'sd57;
			5'd31: v = 40'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/vector_to_lon_lat.sv =====
// ----------------------------------------------------------------------------
// vector_to_lon_lat: Cartesian vector to longitude and latitude in degrees
// Squares, a 32-cell square root chain, two 32-cell CORDIC chains, rounding.
// ----------------------------------------------------------------------------
// Pipeline: 68 register stages; result_valid is the last bit of the valid
//   pipeline and marks the result held in the output register.
// Throughput: one vector per cycle; busy stays low, every cell advances each
//   cycle, so the 68-stage pipeline sets latency and never the rate.
// Reset: clears the valid pipeline and loads pole_q with its default;
//   payload registers are left as they are. The receiver cannot stall.
module vector_to_lon_lat (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic               last_item,
	input  logic               cfg_we,
	input  logic [28:0]        cfg_wdata,
	output logic               result_valid,
	output logic [30:0]        lon_deg,
	output logic signed [29:0] lat_deg,
	output logic               last_out
);

	localparam int N = vtl_pkg::N_ITER;

	// configuration register
	logic [28:0] pole_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q <= vtl_pkg::POLE_RST;
		end else if (cfg_we) begin
			pole_q <= cfg_wdata;
		end
	end

	// the pipeline never stalls: take every start
	assign busy = 1'b0;

	// valid bit per stage; advance each cycle
	logic [vtl_pkg::LATENCY-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[vtl_pkg::LATENCY-2:0], start};
		end
	end

	// stage 1: squares, one multiplier each for x and y
	logic signed [63:0] sqx_s1, sqy_s1;
	vtl_pkg::vec_t      in_s1;

	always_ff @(posedge clk) begin
		sqx_s1 <= 64'(vec_x) * 64'(vec_x);
		sqy_s1 <= 64'(vec_y) * 64'(vec_y);
		in_s1  <= '{x: vec_x, y: vec_y, z: vec_z, last: last_item};
	end

	// stage 2: sum of squares, at most 2^63 so it fits unsigned
	logic [63:0]   sum_s2;
	vtl_pkg::vec_t in_s2;

	always_ff @(posedge clk) begin
		sum_s2 <= unsigned'(sqx_s1) + unsigned'(sqy_s1);
		in_s2  <= in_s1;
	end

	// square root chain: one root bit per cell, sideband travels alongside
	vtl_pkg::sq_t  sq_chain [0:N];
	vtl_pkg::vec_t sqsb_s   [0:N];

	assign sq_chain[0] = '{rem: sum_s2, root: '0};
	assign sqsb_s[0]   = in_s2;

	for (genvar k = 0; k < N; k++) begin : g_sqrt
		vtl_sqrt_cell u_cell (
			.clk  (clk),
			.idx  (vtl_pkg::IDX_W'(k)),
			.din  (sq_chain[k]),
			.dout (sq_chain[k+1])
		);

		always_ff @(posedge clk) begin
			sqsb_s[k+1] <= sqsb_s[k];
		end
	end

	// seed both CORDIC chains; left half-plane is folded by negating x and y
	vtl_pkg::vec_t      sb_end;
	logic signed [63:0] xe, ye, ax, by;
	vtl_pkg::cd_t       lat_chain [0:N];
	vtl_pkg::cd_t       lon_chain [0:N];
	vtl_pkg::flags_t    cdsb_s    [0:N];

	always_comb begin
		sb_end = sqsb_s[N];
		xe     = 64'(sb_end.x);
		ye     = 64'(sb_end.y);
		ax     = sb_end.x[31] ? -xe : xe;
		by     = sb_end.x[31] ? -ye : ye;
		lat_chain[0].xa  = {5'd0, sq_chain[N].root[31:0], 27'd0};
		lat_chain[0].yb  = {{5{sb_end.z[31]}}, sb_end.z, 27'd0};
		lat_chain[0].ang = '0;
		lon_chain[0].xa  = {ax[36:0], 27'd0};
		lon_chain[0].yb  = {by[36:0], 27'd0};
		lon_chain[0].ang = '0;
		cdsb_s[0].last    = sb_end.last;
		cdsb_s[0].xy_zero = (sb_end.x == '0) && (sb_end.y == '0);
		cdsb_s[0].x_neg   = sb_end.x[31];
		cdsb_s[0].z_pos   = !sb_end.z[31] && (sb_end.z != '0);
		cdsb_s[0].z_neg   = sb_end.z[31];
	end

	for (genvar k = 0; k < N; k++) begin : g_cordic
		vtl_cordic_cell u_lat (
			.clk  (clk),
			.idx  (vtl_pkg::IDX_W'(k)),
			.din  (lat_chain[k]),
			.dout (lat_chain[k+1])
		);

		vtl_cordic_cell u_lon (
			.clk  (clk),
			.idx  (vtl_pkg::IDX_W'(k)),
			.din  (lon_chain[k]),
			.dout (lon_chain[k+1])
		);

		always_ff @(posedge clk) begin
			cdsb_s[k+1] <= cdsb_s[k];
		end
	end

	// rounding stage: add half an output step, floor to 2^-22 degree
	logic signed [vtl_pkg::ACC_W-1:0] lat_acc, lon_acc, lat_rnd, lon_rnd;
	logic signed [29:0]               lat_s67;
	logic signed [31:0]               lon_s67;
	vtl_pkg::flags_t                  fl_s67;

	always_comb begin
		lat_acc = lat_chain[N].ang;
		lon_acc = lon_chain[N].ang + (cdsb_s[N].x_neg ? vtl_pkg::HALF_TURN : '0);
		lat_rnd = (lat_acc + vtl_pkg::RND_HALF) >>> vtl_pkg::RND_SHIFT;
		lon_rnd = (lon_acc + vtl_pkg::RND_HALF) >>> vtl_pkg::RND_SHIFT;
	end

	always_ff @(posedge clk) begin
		fl_s67  <= cdsb_s[N];
		lon_s67 <= lon_rnd[31:0];
		// on the z axis the latitude is exactly a quarter turn
		if (cdsb_s[N].xy_zero) begin
			lat_s67 <= cdsb_s[N].z_pos ? vtl_pkg::QUARTER :
			           (cdsb_s[N].z_neg ? -vtl_pkg::QUARTER : '0);
		end else begin
			lat_s67 <= lat_rnd[29:0];
		end
	end

	// output stage: pole forcing and wrap into one turn
	logic [29:0]        lat_mag;
	logic               force_zero;
	logic signed [31:0] lon_wrap;

	always_comb begin
		lat_mag    = lat_s67[29] ? 30'(-lat_s67) : 30'(lat_s67);
		force_zero = (lat_mag > {1'b0, pole_q}) || fl_s67.xy_zero;
		if (force_zero) begin
			lon_wrap = '0;
		end else if (lon_s67[31]) begin
			lon_wrap = lon_s67 + vtl_pkg::FULL_TURN;
		end else if (lon_s67 >= vtl_pkg::FULL_TURN) begin
			lon_wrap = lon_s67 - vtl_pkg::FULL_TURN;
		end else begin
			lon_wrap = lon_s67;
		end
	end

	logic [30:0]        lon_q;
	logic signed [29:0] lat_q;
	logic               last_q;

	always_ff @(posedge clk) begin
		lon_q  <= lon_wrap[30:0];
		lat_q  <= lat_s67;
		last_q <= fl_s67.last;
	end

	assign result_valid = vld_q[vtl_pkg::LATENCY-1];
	assign lon_deg      = lon_q;
	assign lat_deg      = lat_q;
	assign last_out     = last_q;

	// checks
	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, lon_deg} < vtl_pkg::FULL_TURN))
		else $error("longitude outside one turn");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (lat_deg <= vtl_pkg::QUARTER && lat_deg >= -vtl_pkg::QUARTER))
		else $error("latitude beyond a pole");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && vec_x == '0 && vec_y == '0 && vec_z == '0)
		|-> ##68 (result_valid && lat_deg == '0 && lon_deg == '0))
		else $error("zero vector did not give zero angles");

endmodule

// ===== hw/rtl/vtl_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vtl_sqrt_cell: one digit of the integer square root
// Trial-subtracts one root bit and hands remainder and partial root onward.
// ----------------------------------------------------------------------------
module vtl_sqrt_cell (
	input  logic                            clk,
	input  logic [vtl_pkg::IDX_W-1:0]       idx,
	input  vtl_pkg::sq_t                    din,
	output vtl_pkg::sq_t                    dout
);

	logic [vtl_pkg::VEC_W-1:0] bit_w;
	logic [vtl_pkg::VEC_W-1:0] trial;
	vtl_pkg::sq_t              nxt;

	always_comb begin
		bit_w = 64'd1 << (6'd62 - {idx, 1'b0});
		trial = din.root + bit_w;
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = (din.root >> 1) + bit_w;
		end else begin
			nxt.rem  = din.rem;
			nxt.root = din.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

// ===== hw/rtl/vtl_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// vtl_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates towards the x axis and accumulates the table angle.
// ----------------------------------------------------------------------------
module vtl_cordic_cell (
	input  logic                            clk,
	input  logic [vtl_pkg::IDX_W-1:0]       idx,
	input  vtl_pkg::cd_t                    din,
	output vtl_pkg::cd_t                    dout
);

	logic signed [vtl_pkg::VEC_W-1:0] dx;
	logic signed [vtl_pkg::VEC_W-1:0] dy;
	logic signed [vtl_pkg::ACC_W-1:0] da;
	vtl_pkg::cd_t                     nxt;

	always_comb begin
		dx = din.yb >>> idx;
		dy = din.xa >>> idx;
		da = vtl_pkg::atan_tab(idx);
		if (!din.yb[vtl_pkg::VEC_W-1]) begin
			nxt.xa  = din.xa + dx;
			nxt.yb  = din.yb - dy;
			nxt.ang = din.ang + da;
		end else begin
			nxt.xa  = din.xa - dx;
			nxt.yb  = din.yb + dy;
			nxt.ang = din.ang - da;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule
